FILE: rtl/pts_pkg.sv
// Shared types, constants and helper functions of the polynomial-time texture sampler.
package pts_pkg;

	// Store geometry
	localparam int MAX_WIDTH   = 32;
	localparam int MAX_HEIGHT  = 32;
	localparam int POLY_DEGREE = 5;
	localparam int MAP_COUNT   = 8;
	localparam int COEF_COUNT  = POLY_DEGREE + 1;
	localparam int STORE_DEPTH = MAP_COUNT * COEF_COUNT * MAX_HEIGHT * MAX_WIDTH;

	localparam int X_W    = $clog2(MAX_WIDTH);
	localparam int Y_W    = $clog2(MAX_HEIGHT);
	localparam int IDX_W  = (X_W > Y_W) ? X_W : Y_W;
	localparam int MAP_W  = 3;
	localparam int POW_W  = 3;
	localparam int MP_W   = $clog2(MAP_COUNT * COEF_COUNT);
	localparam int ADDR_W = MP_W + Y_W + X_W;

	// Field and register widths
	localparam int DATA_W    = 32;
	localparam int SIZE_W    = 6;
	localparam int TIME_W    = 17;
	localparam int RESULT_W  = 31;
	localparam int FRAC_W    = 16;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	// Fixed point
	localparam int ONE_Q16  = 65536;
	localparam int HALF_Q16 = ONE_Q16 / 2;
	localparam int MULB_W   = TIME_W + 1;
	localparam int ACC_W    = DATA_W + MULB_W;
	localparam int HSH_W    = ACC_W - FRAC_W;
	localparam int HSUM_W   = HSH_W + 1;
	localparam int SPROD_W  = FRAC_W + SIZE_W;
	localparam int SS_W     = SPROD_W + 1;

	// Item command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Texel order: p00, p10, p01, p11
	localparam logic [1:0] TEXEL_LAST = 2'd3;

	// Register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_TEX_WIDTH  = 2'd0,
		REG_TEX_HEIGHT = 2'd1,
		REG_TIME_POS   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DRAIN,
		ST_BLEND,
		ST_DONE
	} state_t;

	// Blend multiply-accumulate steps
	typedef enum logic [2:0] {
		BL_P00  = 3'd0,
		BL_P10  = 3'd1,
		BL_P01  = 3'd2,
		BL_P11  = 3'd3,
		BL_ROW0 = 3'd4,
		BL_ROW1 = 3'd5
	} blend_step_t;

	typedef struct packed {
		logic [SIZE_W-1:0] tex_width;
		logic [SIZE_W-1:0] tex_height;
		logic [TIME_W-1:0] time_pos;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              write_coef;
		logic              start_sample;
		logic              rd_en;
		logic [1:0]        rd_texel;
		logic [POW_W-1:0]  rd_pow;
		logic              rd_first;
		logic              rd_last;
		logic              blend_en;
		blend_step_t       blend_step;
		logic              load_out;
	} ctl_t;

endpackage

FILE: rtl/poly_time_texture_sampler_top.sv
// Top level of the polynomial-time bilinear texture sampler.
// A coefficient write word is taken while idle and produces no result. A sample word
// is answered after the steps that follow, and the next word can be taken once the result
// is loaded: the four neighbor texels times six coefficients are read one per cycle from
// the single coefficient memory and folded by Horner steps on the shared multiplier, a
// drain step waits for the last read, six multiply-accumulate steps on the same
// multiplier blend the texels, and a final step loads the output register. The next word
// is taken while a finished result waits; a second result waits in the sequencer until
// the first is taken. The coefficient memory is not cleared by reset; entries read before
// they are written return unknown data.
module poly_time_texture_sampler_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pts_pkg::PADDR_W-1:0]          paddr,
	input  logic [pts_pkg::PDATA_W-1:0]          pwdata,
	output logic [pts_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic                                 cmd,
	input  logic [pts_pkg::MAP_W-1:0]            map_select,
	input  logic [pts_pkg::POW_W-1:0]            coef_index,
	input  logic [pts_pkg::X_W-1:0]              texel_x,
	input  logic [pts_pkg::Y_W-1:0]              texel_y,
	input  logic signed [pts_pkg::DATA_W-1:0]    coef_value,
	input  logic signed [pts_pkg::DATA_W-1:0]    u_coord,
	input  logic signed [pts_pkg::DATA_W-1:0]    v_coord,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [pts_pkg::RESULT_W-1:0]         sample_value
);
	import pts_pkg::*;

	cfg_t cfg;
	ctl_t ctl;

	pts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_cmd     (cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.ctl          (ctl)
	);

	pts_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg),
		.map_select   (map_select),
		.coef_index   (coef_index),
		.texel_x      (texel_x),
		.texel_y      (texel_y),
		.coef_value   (coef_value),
		.u_coord      (u_coord),
		.v_coord      (v_coord),
		.sample_value (sample_value)
	);

endmodule

FILE: rtl/pts_regs.sv
// APB configuration registers: texture width, height and evaluation time.
module pts_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pts_pkg::PADDR_W-1:0]  paddr,
	input  logic [pts_pkg::PDATA_W-1:0]  pwdata,
	output logic [pts_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output pts_pkg::cfg_t                cfg
);
	import pts_pkg::*;

	logic              wr_en;
	reg_idx_t          idx;
	logic [SIZE_W-1:0] tex_width_q;
	logic [SIZE_W-1:0] tex_height_q;
	logic [TIME_W-1:0] time_pos_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= SIZE_W'(MAX_WIDTH);
			tex_height_q <= SIZE_W'(MAX_HEIGHT);
			time_pos_q   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_TEX_WIDTH:  tex_width_q  <= pwdata[SIZE_W-1:0];
				REG_TEX_HEIGHT: tex_height_q <= pwdata[SIZE_W-1:0];
				REG_TIME_POS:   time_pos_q   <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_TEX_WIDTH:  prdata = PDATA_W'(tex_width_q);
			REG_TEX_HEIGHT: prdata = PDATA_W'(tex_height_q);
			REG_TIME_POS:   prdata = PDATA_W'(time_pos_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.tex_width  = tex_width_q;
	assign cfg.tex_height = tex_height_q;
	assign cfg.time_pos   = time_pos_q;

endmodule

FILE: rtl/pts_ctrl.sv
// Sequencer: accepts words, walks the coefficient fetch and blend steps, owns result valid.
module pts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  logic          item_cmd,
	output logic          result_valid,
	input  logic          result_ready,
	output pts_pkg::ctl_t ctl
);
	import pts_pkg::*;

	state_t           state_q;
	state_t           state_nxt;
	logic [1:0]       texel_q;
	logic [POW_W-1:0] pow_q;
	blend_step_t      bstep_q;
	logic             accept;
	logic             fetch_end;
	logic             out_free;
	logic             result_valid_q;

	assign accept    = item_valid & item_ready;
	assign fetch_end = (texel_q == TEXEL_LAST) && (pow_q == '0);
	assign out_free  = !result_valid_q || result_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (item_valid && item_cmd == CMD_SAMPLE) state_nxt = ST_FETCH;
			ST_FETCH: if (fetch_end) state_nxt = ST_DRAIN;
			ST_DRAIN: state_nxt = ST_BLEND;
			ST_BLEND: if (bstep_q == BL_ROW1) state_nxt = ST_DONE;
			ST_DONE:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready       = 1'b0;
		ctl              = '0;
		ctl.rd_texel     = texel_q;
		ctl.rd_pow       = pow_q;
		ctl.rd_first     = (pow_q == POW_W'(POLY_DEGREE));
		ctl.rd_last      = (pow_q == '0);
		ctl.blend_step   = bstep_q;
		unique case (state_q)
			ST_IDLE: begin
				item_ready       = 1'b1;
				ctl.write_coef   = accept && (item_cmd == CMD_WRITE);
				ctl.start_sample = accept && (item_cmd == CMD_SAMPLE);
			end
			ST_FETCH: ctl.rd_en    = 1'b1;
			ST_DRAIN: ;
			ST_BLEND: ctl.blend_en = 1'b1;
			ST_DONE:  ctl.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// fetch and blend counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_q <= '0;
			pow_q   <= POW_W'(POLY_DEGREE);
			bstep_q <= BL_P00;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					texel_q <= '0;
					pow_q   <= POW_W'(POLY_DEGREE);
				end
				ST_FETCH: begin
					if (pow_q == '0) begin
						pow_q   <= POW_W'(POLY_DEGREE);
						texel_q <= texel_q + 2'd1;
					end else begin
						pow_q <= pow_q - POW_W'(1);
					end
				end
				ST_DRAIN: bstep_q <= BL_P00;
				ST_BLEND: bstep_q <= blend_step_t'(bstep_q + 3'd1);
				default: ;
			endcase
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

endmodule

FILE: rtl/pts_dpath.sv
// Datapath: coefficient memory, coordinate setup, Horner evaluator and bilinear blend.
module pts_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pts_pkg::ctl_t                  ctl,
	input  pts_pkg::cfg_t                  cfg,
	input  logic [pts_pkg::MAP_W-1:0]      map_select,
	input  logic [pts_pkg::POW_W-1:0]      coef_index,
	input  logic [pts_pkg::X_W-1:0]        texel_x,
	input  logic [pts_pkg::Y_W-1:0]        texel_y,
	input  logic signed [pts_pkg::DATA_W-1:0] coef_value,
	input  logic signed [pts_pkg::DATA_W-1:0] u_coord,
	input  logic signed [pts_pkg::DATA_W-1:0] v_coord,
	output logic [pts_pkg::RESULT_W-1:0]   sample_value
);
	import pts_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic [FRAC_W-1:0] frac;
	} axis_t;

	// Neighbor indices and fraction along one axis: (frac*size - 0.5) split into
	// integer step and fraction; the integer part of the coordinate drops out mod size.
	function automatic axis_t axis_setup(input logic [FRAC_W-1:0] uf,
	                                     input logic [SIZE_W-1:0] size);
		logic [SPROD_W-1:0]     p;
		logic signed [SS_W-1:0] s;
		logic [IDX_W-1:0]       last;
		axis_t                  a;
		p      = SPROD_W'(uf) * SPROD_W'(size);
		s      = $signed({1'b0, p}) - $signed(SS_W'(HALF_Q16));
		last   = IDX_W'(size - SIZE_W'(1));
		a.lo   = s[SS_W-1] ? last : s[FRAC_W +: IDX_W];
		a.hi   = (a.lo == last) ? '0 : a.lo + IDX_W'(1);
		a.frac = s[FRAC_W-1:0];
		return a;
	endfunction

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
	                                                input int unsigned mx);
		logic [SIZE_W-1:0] r;
		if (s == '0) begin
			r = SIZE_W'(1);
		end else if (s > SIZE_W'(mx)) begin
			r = SIZE_W'(mx);
		end else begin
			r = s;
		end
		return r;
	endfunction

	logic [DATA_W-1:0] mem [STORE_DEPTH];

	logic [SIZE_W-1:0]        eff_w;
	logic [SIZE_W-1:0]        eff_h;
	axis_t                    ax;
	axis_t                    ay;
	logic [MP_W-1:0]          wr_mp;
	logic [ADDR_W-1:0]        wr_addr;
	logic                     mem_we;
	logic [MP_W-1:0]          rd_mp;
	logic [X_W-1:0]           rd_x;
	logic [Y_W-1:0]           rd_y;
	logic [ADDR_W-1:0]        rd_addr;

	logic [MAP_W-1:0]         map_q;
	logic [X_W-1:0]           x0_q;
	logic [X_W-1:0]           x1_q;
	logic [Y_W-1:0]           y0_q;
	logic [Y_W-1:0]           y1_q;
	logic [FRAC_W-1:0]        fx_q;
	logic [FRAC_W-1:0]        fy_q;
	logic [TIME_W-1:0]        t_q;

	logic signed [DATA_W-1:0] rdata_s1;
	logic                     hv_s1;
	logic                     hfirst_s1;
	logic                     hlast_s1;
	logic [1:0]               htexel_s1;

	logic signed [DATA_W-1:0] r_q;
	logic signed [DATA_W-1:0] pix_q [4];
	logic signed [DATA_W-1:0] row0_q;
	logic signed [DATA_W-1:0] row1_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [RESULT_W-1:0]      sample_value_q;

	logic signed [DATA_W-1:0] mul_a;
	logic [TIME_W-1:0]        mul_b;
	logic signed [MULB_W-1:0] mul_b_s;
	logic signed [ACC_W-1:0]  prod;
	logic                     acc_add;
	logic [TIME_W-1:0]        ofx;
	logic [TIME_W-1:0]        ofy;
	logic signed [HSH_W-1:0]  h_shift;
	logic signed [HSUM_W-1:0] h_sum;
	logic signed [DATA_W-1:0] r_next;
	logic signed [DATA_W-1:0] res;

	// coordinate setup on sample acceptance
	assign eff_w = clamp_size(cfg.tex_width, MAX_WIDTH);
	assign eff_h = clamp_size(cfg.tex_height, MAX_HEIGHT);
	assign ax    = axis_setup(u_coord[FRAC_W-1:0], eff_w);
	assign ay    = axis_setup(v_coord[FRAC_W-1:0], eff_h);

	always_ff @(posedge clk) begin
		if (ctl.start_sample) begin
			map_q <= map_select;
			x0_q  <= X_W'(ax.lo);
			x1_q  <= X_W'(ax.hi);
			y0_q  <= Y_W'(ay.lo);
			y1_q  <= Y_W'(ay.hi);
			fx_q  <= ax.frac;
			fy_q  <= ay.frac;
			t_q   <= (cfg.time_pos > TIME_W'(ONE_Q16)) ? TIME_W'(ONE_Q16) : cfg.time_pos;
		end
	end

	// coefficient memory: write from the item word, read during fetch
	assign wr_mp   = MP_W'(MP_W'(map_select) * MP_W'(COEF_COUNT) + MP_W'(coef_index));
	assign wr_addr = {wr_mp, texel_y, texel_x};
	assign mem_we  = ctl.write_coef && (coef_index <= POW_W'(POLY_DEGREE));

	assign rd_mp   = MP_W'(MP_W'(map_q) * MP_W'(COEF_COUNT) + MP_W'(ctl.rd_pow));
	assign rd_x    = ctl.rd_texel[0] ? x1_q : x0_q;
	assign rd_y    = ctl.rd_texel[1] ? y1_q : y0_q;
	assign rd_addr = {rd_mp, rd_y, rd_x};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= coef_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_s1 <= $signed(mem[rd_addr]);
		end
	end

	// read-data tags, registered alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s1     <= 1'b0;
			hfirst_s1 <= 1'b0;
			hlast_s1  <= 1'b0;
			htexel_s1 <= '0;
		end else begin
			hv_s1     <= ctl.rd_en;
			hfirst_s1 <= ctl.rd_first;
			hlast_s1  <= ctl.rd_last;
			htexel_s1 <= ctl.rd_texel;
		end
	end

	// shared multiplier operand select
	assign ofx = TIME_W'(ONE_Q16) - TIME_W'(fx_q);
	assign ofy = TIME_W'(ONE_Q16) - TIME_W'(fy_q);

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		acc_add = 1'b0;
		if (hv_s1) begin
			mul_a = hfirst_s1 ? '0 : r_q;
			mul_b = t_q;
		end else if (ctl.blend_en) begin
			unique case (ctl.blend_step)
				BL_P00:  begin mul_a = pix_q[0]; mul_b = ofx; end
				BL_P10:  begin mul_a = pix_q[1]; mul_b = TIME_W'(fx_q); acc_add = 1'b1; end
				BL_P01:  begin mul_a = pix_q[2]; mul_b = ofx; end
				BL_P11:  begin mul_a = pix_q[3]; mul_b = TIME_W'(fx_q); acc_add = 1'b1; end
				BL_ROW0: begin mul_a = row0_q; mul_b = ofy; end
				BL_ROW1: begin mul_a = row1_q; mul_b = TIME_W'(fy_q); acc_add = 1'b1; end
				default: ;
			endcase
		end
	end

	assign mul_b_s = $signed({1'b0, mul_b});
	assign prod    = mul_a * mul_b_s;

	// Horner step: sat32(floor(r*t/65536) + c)
	assign h_shift = $signed(prod[ACC_W-1:FRAC_W]);
	assign h_sum   = HSUM_W'(h_shift) + HSUM_W'(rdata_s1);

	always_comb begin
		if (h_sum[HSUM_W-1:DATA_W-1] == {(HSUM_W-DATA_W+1){h_sum[DATA_W-1]}}) begin
			r_next = h_sum[DATA_W-1:0];
		end else if (h_sum[HSUM_W-1]) begin
			r_next = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r_next = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (hv_s1) begin
			r_q <= r_next;
			if (hlast_s1) begin
				pix_q[htexel_s1] <= r_next;
			end
		end
	end

	// blend accumulator and row results
	always_ff @(posedge clk) begin
		if (ctl.blend_en) begin
			acc_q <= acc_add ? (acc_q + prod) : prod;
			if (ctl.blend_step == BL_P01) begin
				row0_q <= acc_q[FRAC_W +: DATA_W];
			end
			if (ctl.blend_step == BL_ROW0) begin
				row1_q <= acc_q[FRAC_W +: DATA_W];
			end
		end
	end

	// output word, clamped at zero
	assign res = acc_q[FRAC_W +: DATA_W];

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			sample_value_q <= res[DATA_W-1] ? '0 : res[RESULT_W-1:0];
		end
	end

	assign sample_value = sample_value_q;

endmodule

FILE: rtl/pts_checker.sv
// Port-level checks for the texture sampler, bound to the top level.
module pts_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic [pts_pkg::PDATA_W-1:0]          prdata,
	input logic                                 item_valid,
	input logic                                 item_ready,
	input logic                                 cmd,
	input logic                                 result_valid,
	input logic                                 result_ready,
	input logic [pts_pkg::RESULT_W-1:0]         sample_value
);
	import pts_pkg::*;

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(sample_value))
		else $error("result word changed while stalled");

	// an accepted sample keeps the block busy in the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && cmd == CMD_SAMPLE |=> !item_ready)
		else $error("input ready right after a sample was accepted");

	// a coefficient write never raises a result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && cmd == CMD_WRITE && !result_valid |=> !result_valid)
		else $error("result appeared after a coefficient write");

	// a new result only appears while the block is busy with a sample
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared while idle");

	// register reads never carry bits above the widest register
	a_prdata_width: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[PDATA_W-1:TIME_W] == '0)
		else $error("register read data out of range");

endmodule

bind poly_time_texture_sampler_top pts_checker u_pts_checker (.*);
